@@ hdl/slbs_pkg.sv @@
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types, constants and pattern tables for the status LED blink
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package slbs_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned StepW = 3;
  localparam int unsigned DurW  = 8;
  localparam int unsigned CntW  = 5;

  // Register reset values
  localparam logic [CfgW-1:0] JoinHpRst   = 16'd100;
  localparam logic [CfgW-1:0] PortalHpRst = 16'd500;
  localparam logic [CfgW-1:0] LinkChkRst  = 16'd500;
  localparam logic [CfgW-1:0] RefreshRst  = 16'd1000;

  // Overlay step durations (ms)
  localparam logic [DurW-1:0] DurWink    = 8'd80;
  localparam logic [DurW-1:0] DurGap     = 8'd150;
  localparam logic [DurW-1:0] DurProfile = 8'd100;

  typedef enum logic [1:0] {
    CFG_JOIN_HP   = 2'd0,
    CFG_PORTAL_HP = 2'd1,
    CFG_LINK_CHK  = 2'd2,
    CFG_REFRESH   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_JOIN   = 2'd0,
    MODE_PORTAL = 2'd1,
    MODE_CONN   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PAT_NONE    = 2'd0,
    PAT_WINK    = 2'd1,
    PAT_DOUBLE  = 2'd2,
    PAT_PROFILE = 2'd3
  } pattern_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINK_DIFF,
    ST_LINK_CMP,
    ST_EVENTS,
    ST_DIV,
    ST_PAT_DIFF,
    ST_PAT_CMP,
    ST_PAT_ADV,
    ST_REF_DIFF,
    ST_REF_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CfgW-1:0] join_hp;
    logic [CfgW-1:0] portal_hp;
    logic [CfgW-1:0] link_chk;
    logic [CfgW-1:0] refresh;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [1:0]       mode;
    logic             wifi_up;
    logic             link_connected;
    logic             ev_start;
    logic             ev_failed;
    logic             ev_profile;
  } item_t;

  typedef struct packed {
    logic     led_on;
    logic     led_write;
    pattern_e active_pattern;
  } result_t;

  function automatic logic [StepW-1:0] pat_len(pattern_e sel);
    logic [StepW-1:0] len;
    unique case (sel)
      PAT_NONE:    len = 3'd0;
      PAT_WINK:    len = 3'd1;
      PAT_DOUBLE:  len = 3'd3;
      PAT_PROFILE: len = 3'd5;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DurW-1:0] pat_dur(pattern_e sel, logic [StepW-1:0] idx);
    logic [DurW-1:0] dur;
    unique case (sel)
      PAT_WINK:    dur = DurWink;
      PAT_DOUBLE:  dur = (idx == 3'd1) ? DurGap : DurWink;
      PAT_PROFILE: dur = DurProfile;
      default:     dur = '0;
    endcase
    return dur;
  endfunction

endpackage

`default_nettype wire

@@ hdl/slbs_alu.sv @@
// ----------------------------------------------------------------------------
// slbs_alu
// Shared 32-bit add/subtract unit with carry (add) or borrow (subtract) out.
// ----------------------------------------------------------------------------
`default_nettype none

module slbs_alu (
  input  slbs_pkg::alu_op_e              op_i,
  input  logic [slbs_pkg::TimeW-1:0]     a_i,
  input  logic [slbs_pkg::TimeW-1:0]     b_i,
  output logic [slbs_pkg::TimeW-1:0]     res_o,
  output logic                           carry_o
);

  logic [slbs_pkg::TimeW:0] full;

  always_comb begin
    unique case (op_i)
      slbs_pkg::ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      slbs_pkg::ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default:           full = '0;
    endcase
  end

  assign res_o   = full[slbs_pkg::TimeW-1:0];
  assign carry_o = full[slbs_pkg::TimeW];

endmodule

`default_nettype wire

@@ hdl/slbs_core.sv @@
// ----------------------------------------------------------------------------
// slbs_core
// Sequencer and state for one tick: link sample, event handling, blink
// divider or overlay catch-up, and write decision, all on the shared ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module slbs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  slbs_pkg::item_t   item_i,
  input  slbs_pkg::cfg_t    cfg_i,
  output logic              idle_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output slbs_pkg::result_t res_o
);

  localparam int unsigned TW = slbs_pkg::TimeW;
  localparam int unsigned CW = slbs_pkg::CfgW;

  slbs_pkg::state_e   state_q, state_d;

  // persistent state
  slbs_pkg::pattern_e           pat_q, pat_d;
  logic [slbs_pkg::StepW-1:0]   step_q, step_d;
  logic [TW-1:0]                step_start_q, step_start_d;
  logic [TW-1:0]                last_write_q, last_write_d;
  logic [TW-1:0]                last_chk_q, last_chk_d;
  logic                         link_smp_q, link_smp_d;
  logic                         last_level_q, last_level_d;
  logic                         written_q, written_d;

  // per-tick working registers
  logic [TW-1:0]                now_q, now_d;
  slbs_pkg::mode_e              mode_q, mode_d;
  logic                         wifi_q, wifi_d;
  logic                         link_q, link_d;
  logic                         ev_start_q, ev_start_d;
  logic                         ev_failed_q, ev_failed_d;
  logic                         ev_profile_q, ev_profile_d;
  logic [TW-1:0]                acc_q, acc_d;
  logic [CW-1:0]                rem_q, rem_d;
  logic [TW-1:0]                dvd_q, dvd_d;
  logic [slbs_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                         on_q, on_d;
  logic                         wr_q, wr_d;

  // shared unit
  slbs_pkg::alu_op_e            alu_op;
  logic [TW-1:0]                alu_a, alu_b, alu_res;
  logic                         alu_carry;

  logic [CW:0]                  div_r;
  logic [CW-1:0]                div_hp;
  logic [slbs_pkg::DurW-1:0]    dur;
  logic [slbs_pkg::StepW-1:0]   step_nxt;
  logic                         link_now;
  logic                         do_write;

  slbs_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q        <= slbs_pkg::PAT_NONE;
      step_q       <= '0;
      step_start_q <= '0;
      last_write_q <= '0;
      last_chk_q   <= '0;
      link_smp_q   <= 1'b1;
      last_level_q <= 1'b0;
      written_q    <= 1'b0;
    end else begin
      pat_q        <= pat_d;
      step_q       <= step_d;
      step_start_q <= step_start_d;
      last_write_q <= last_write_d;
      last_chk_q   <= last_chk_d;
      link_smp_q   <= link_smp_d;
      last_level_q <= last_level_d;
      written_q    <= written_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    mode_q       <= mode_d;
    wifi_q       <= wifi_d;
    link_q       <= link_d;
    ev_start_q   <= ev_start_d;
    ev_failed_q  <= ev_failed_d;
    ev_profile_q <= ev_profile_d;
    acc_q        <= acc_d;
    rem_q        <= rem_d;
    dvd_q        <= dvd_d;
    cnt_q        <= cnt_d;
    on_q         <= on_d;
    wr_q         <= wr_d;
  end

  // divider operands: restoring step, one quotient bit per cycle
  assign div_r  = {rem_q, dvd_q[TW-1]};
  assign div_hp = (mode_q == slbs_pkg::MODE_JOIN) ?
                  ((cfg_i.join_hp == '0) ? 16'd1 : cfg_i.join_hp) :
                  ((cfg_i.portal_hp == '0) ? 16'd1 : cfg_i.portal_hp);

  assign dur      = slbs_pkg::pat_dur(pat_q, step_q);
  assign step_nxt = step_q + 3'd1;

  always_comb begin
    state_d      = state_q;
    pat_d        = pat_q;
    step_d       = step_q;
    step_start_d = step_start_q;
    last_write_d = last_write_q;
    last_chk_d   = last_chk_q;
    link_smp_d   = link_smp_q;
    last_level_d = last_level_q;
    written_d    = written_q;
    now_d        = now_q;
    mode_d       = mode_q;
    wifi_d       = wifi_q;
    link_d       = link_q;
    ev_start_d   = ev_start_q;
    ev_failed_d  = ev_failed_q;
    ev_profile_d = ev_profile_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    cnt_d        = cnt_q;
    on_d         = on_q;
    wr_d         = wr_q;
    alu_op       = slbs_pkg::ALU_SUB;
    alu_a        = now_q;
    alu_b        = '0;
    link_now     = link_smp_q;
    do_write     = 1'b0;
    idle_o       = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      slbs_pkg::ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          now_d        = item_i.now_ms;
          // mode code three behaves as connected
          mode_d       = (item_i.mode == 2'd3) ? slbs_pkg::MODE_CONN :
                         slbs_pkg::mode_e'(item_i.mode);
          wifi_d       = item_i.wifi_up;
          link_d       = item_i.link_connected;
          ev_start_d   = item_i.ev_start;
          ev_failed_d  = item_i.ev_failed;
          ev_profile_d = item_i.ev_profile;
          state_d      = slbs_pkg::ST_LINK_DIFF;
        end
      end

      slbs_pkg::ST_LINK_DIFF: begin
        alu_b = last_chk_q;
        acc_d = alu_res;
        state_d = wifi_q ? slbs_pkg::ST_LINK_CMP : slbs_pkg::ST_EVENTS;
      end

      slbs_pkg::ST_LINK_CMP: begin
        alu_a = acc_q;
        alu_b = {16'd0, cfg_i.link_chk};
        if (!alu_carry) begin
          last_chk_d = now_q;
          link_smp_d = link_q;
          link_now   = link_q;
        end
        mode_d  = link_now ? slbs_pkg::MODE_CONN : slbs_pkg::MODE_JOIN;
        state_d = slbs_pkg::ST_EVENTS;
      end

      slbs_pkg::ST_EVENTS: begin
        if (mode_q == slbs_pkg::MODE_CONN) begin
          on_d    = 1'b1;
          state_d = slbs_pkg::ST_PAT_DIFF;
          priority if (ev_profile_q) begin
            pat_d        = slbs_pkg::PAT_PROFILE;
            step_d       = '0;
            step_start_d = now_q;
          end else if (pat_q != slbs_pkg::PAT_PROFILE && ev_failed_q) begin
            pat_d        = slbs_pkg::PAT_DOUBLE;
            step_d       = '0;
            step_start_d = now_q;
          end else if (pat_q == slbs_pkg::PAT_NONE && ev_start_q) begin
            pat_d        = slbs_pkg::PAT_WINK;
            step_d       = '0;
            step_start_d = now_q;
          end else begin
            pat_d = pat_q;
          end
        end else begin
          // outside connected mode the overlay is dropped
          pat_d   = slbs_pkg::PAT_NONE;
          step_d  = '0;
          rem_d   = '0;
          dvd_d   = now_q;
          cnt_d   = '1;
          state_d = slbs_pkg::ST_DIV;
        end
      end

      slbs_pkg::ST_DIV: begin
        alu_a = {15'd0, div_r};
        alu_b = {16'd0, div_hp};
        rem_d = alu_carry ? div_r[CW-1:0] : alu_res[CW-1:0];
        dvd_d = {dvd_q[TW-2:0], 1'b0};
        on_d  = ~alu_carry;          // last one left is the quotient LSB
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = slbs_pkg::ST_REF_DIFF;
        end
      end

      slbs_pkg::ST_PAT_DIFF: begin
        alu_b = step_start_q;
        acc_d = alu_res;
        state_d = (pat_q == slbs_pkg::PAT_NONE) ? slbs_pkg::ST_REF_DIFF :
                  slbs_pkg::ST_PAT_CMP;
      end

      slbs_pkg::ST_PAT_CMP: begin
        alu_a = acc_q;
        alu_b = {24'd0, dur};
        if (alu_carry) begin
          // current step still running: off on even steps
          on_d    = step_q[0];
          state_d = slbs_pkg::ST_REF_DIFF;
        end else begin
          state_d = slbs_pkg::ST_PAT_ADV;
        end
      end

      slbs_pkg::ST_PAT_ADV: begin
        alu_op       = slbs_pkg::ALU_ADD;
        alu_a        = step_start_q;
        alu_b        = {24'd0, dur};
        step_start_d = alu_res;
        if (step_nxt >= slbs_pkg::pat_len(pat_q)) begin
          pat_d  = slbs_pkg::PAT_NONE;
          step_d = '0;
        end else begin
          step_d = step_nxt;
        end
        state_d = slbs_pkg::ST_PAT_DIFF;
      end

      slbs_pkg::ST_REF_DIFF: begin
        alu_b   = last_write_q;
        acc_d   = alu_res;
        state_d = slbs_pkg::ST_REF_CMP;
      end

      slbs_pkg::ST_REF_CMP: begin
        alu_a    = acc_q;
        alu_b    = {16'd0, cfg_i.refresh};
        do_write = !written_q || (on_q != last_level_q) || !alu_carry;
        wr_d     = do_write;
        if (do_write) begin
          last_level_d = on_q;
          last_write_d = now_q;
          written_d    = 1'b1;
        end
        state_d = slbs_pkg::ST_DONE;
      end

      slbs_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = slbs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = slbs_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o.led_on         = on_q;
  assign res_o.led_write      = wr_q;
  assign res_o.active_pattern = pat_q;

endmodule

`default_nettype wire

@@ hdl/status_led_blink_sequencer.sv @@
// ----------------------------------------------------------------------------
// status_led_blink_sequencer
// Status LED sequencer: per poll tick, picks the display mode, runs the
// blink or overlay pattern and decides whether the LED pin is rewritten.
//
//   channel  direction  handshake                payload
//   -------  ---------  -----------------------  ---------------------------
//   in       slave      in_valid_i / in_ready_o  now_ms, mode, flags, events
//   out      master     out_valid_o/out_ready_i  led_on, led_write, pattern
//   cfg      slave      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Sequencing: blink modes run the bit-per-cycle restoring divider
//   (now_ms / half period); connected mode steps through the diff, compare
//   and advance states once per overlay step caught up (at most 5 steps).
//   All time and divider arithmetic shares one 32-bit add/subtract unit.
// in_ready_o is high only while the sequencer is idle.
// The result sits in an output register; the next tick may be accepted and
//   processed while it waits, and the core holds its own result until the
//   register frees up.
// Reset: asynchronous, resets FSM and persistent state and loads the register
//   defaults. cfg writes are always accepted (cfg_ready_o tied high).
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_blink_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] now_ms_i,
  input  logic [1:0]  requested_mode_i,
  input  logic        wifi_up_i,
  input  logic        link_connected_i,
  input  logic        ev_query_start_i,
  input  logic        ev_query_failed_i,
  input  logic        ev_profile_sent_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        led_on_o,
  output logic        led_write_o,
  output logic [1:0]  active_pattern_o,
  // register write port
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  slbs_pkg::cfg_t    cfg_q, cfg_d;
  slbs_pkg::item_t   item;
  slbs_pkg::result_t core_res;
  slbs_pkg::result_t res_q;
  logic              core_idle;
  logic              core_valid;
  logic              out_valid_q, out_valid_d;
  logic              res_ready;
  logic              res_load;

  // ---------------------------------------------------------------- registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (slbs_pkg::cfg_idx_e'(cfg_index_i))
        slbs_pkg::CFG_JOIN_HP:   cfg_d.join_hp   = cfg_data_i;
        slbs_pkg::CFG_PORTAL_HP: cfg_d.portal_hp = cfg_data_i;
        slbs_pkg::CFG_LINK_CHK:  cfg_d.link_chk  = cfg_data_i;
        slbs_pkg::CFG_REFRESH:   cfg_d.refresh   = cfg_data_i;
        default:                 cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.join_hp   <= slbs_pkg::JoinHpRst;
      cfg_q.portal_hp <= slbs_pkg::PortalHpRst;
      cfg_q.link_chk  <= slbs_pkg::LinkChkRst;
      cfg_q.refresh   <= slbs_pkg::RefreshRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------- core
  assign item.now_ms         = now_ms_i;
  assign item.mode           = requested_mode_i;
  assign item.wifi_up        = wifi_up_i;
  assign item.link_connected = link_connected_i;
  assign item.ev_start       = ev_query_start_i;
  assign item.ev_failed      = ev_query_failed_i;
  assign item.ev_profile     = ev_profile_sent_i;

  assign in_ready_o = core_idle;

  slbs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .idle_o      (core_idle),
    .res_valid_o (core_valid),
    .res_ready_i (res_ready),
    .res_o       (core_res)
  );

  // ---------------------------------------------------------------- output
  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;
  assign res_load  = core_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_on_o         = res_q.led_on;
  assign led_write_o      = res_q.led_write;
  assign active_pattern_o = res_q.active_pattern;

endmodule

`default_nettype wire

@@ hdl/slbs_chk.sv @@
// ----------------------------------------------------------------------------
// slbs_chk
// Port-level checks for the status LED blink sequencer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module slbs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        led_on_o,
  input logic        led_write_o,
  input logic [1:0]  active_pattern_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(led_on_o) && $stable(led_write_o) &&
       $stable(active_pattern_o)))
    else $error("result changed while stalled");

  // sequencer is busy right after taking a tick
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accepting a tick");

  // a result does not rise straight after a tick is taken
  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##1 !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result appeared too soon after a tick");

  // with a result pending and not drained, at most one tick gets in
  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && in_valid_i && in_ready_o) |=>
      (!in_ready_o))
    else $error("tick accepted beyond one in flight");

endmodule

bind status_led_blink_sequencer slbs_chk u_slbs_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .led_on_o         (led_on_o),
  .led_write_o      (led_write_o),
  .active_pattern_o (active_pattern_o)
);

`default_nettype wire
